@@ rtl/kbc_pkg.sv @@
// Shared types and constants for the keyed buffer cipher engine.
// No dependencies; imported by every module of the block.
package kbc_pkg;

    localparam int KEY_BYTES = 1024;
    localparam int KEY_AW    = 10;
    localparam int TBL_AW    = 16;

    // request kinds carried on tuser
    localparam logic [2:0] REQ_KEY_WR = 3'd0;
    localparam logic [2:0] REQ_BUILD  = 3'd1;
    localparam logic [2:0] REQ_BUF_WR = 3'd2;
    localparam logic [2:0] REQ_RUN    = 3'd3;
    localparam logic [2:0] REQ_BUF_RD = 3'd4;

    // configuration register indexes
    localparam logic CFG_ROUNDS = 1'b0;
    localparam logic CFG_MODE   = 1'b1;

    // pass operations
    localparam logic [1:0] OP_XOR  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_ROTL = 2'd2;
    localparam logic [1:0] OP_ROTR = 2'd3;

    typedef struct packed {
        logic                 we;
        logic [TBL_AW-1:0]    fwd_addr;
        logic [7:0]           fwd_data;
        logic [TBL_AW-1:0]    inv_addr;
        logic [7:0]           inv_data;
    } t_tbl_wr;

endpackage

@@ rtl/keyed_buffer_cipher_engine.sv @@
// Top level: request decode, key store, data buffer, run sequencer, result register.
// Depends on kbc_pkg, kbc_builder and kbc_tables.
//
// Every request returns one result transaction. Key and buffer writes answer in the
// accept cycle, a buffer read in the cycle after. A table build reads two key bytes,
// then one key byte per table entry and searches a free byte one slot at a time; its
// length is set by the single key-store port and the one-probe-per-cycle search. A
// run is set by the single data-buffer port: an XOR pass reads and writes each byte,
// a substitution pass reads each byte, looks it up and writes it back, and a rotation
// pass loads, rotates and writes back each 8-byte word; a run does one XOR pass plus,
// per round, a keyed phase fetch, one substitution, one XOR and two rotation passes.
module keyed_buffer_cipher_engine import kbc_pkg::*; #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // location[11:0], data_byte[19:12], buf_length[32:20]
    input  logic [2:0]  i_s_axis_tuser,  // req_type[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // read_byte[7:0]
    output logic        o_m_axis_tuser,  // status[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = $clog2(BUF_DEPTH + 1);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RDBUF  = 5'd1;
    localparam logic [4:0] ST_BUILD  = 5'd2;
    localparam logic [4:0] ST_RND    = 5'd3;
    localparam logic [4:0] ST_PHA    = 5'd4;
    localparam logic [4:0] ST_PHB    = 5'd5;
    localparam logic [4:0] ST_PHC    = 5'd6;
    localparam logic [4:0] ST_PASS   = 5'd7;
    localparam logic [4:0] ST_NEXT   = 5'd8;
    localparam logic [4:0] ST_X_RD   = 5'd9;
    localparam logic [4:0] ST_X_WR   = 5'd10;
    localparam logic [4:0] ST_S_RD   = 5'd11;
    localparam logic [4:0] ST_S_TB   = 5'd12;
    localparam logic [4:0] ST_S_WR   = 5'd13;
    localparam logic [4:0] ST_R_127  = 5'd14;
    localparam logic [4:0] ST_R_127C = 5'd15;
    localparam logic [4:0] ST_J_SEL  = 5'd16;
    localparam logic [4:0] ST_J_AMT  = 5'd17;
    localparam logic [4:0] ST_J_AMTC = 5'd18;
    localparam logic [4:0] ST_J_LD   = 5'd19;
    localparam logic [4:0] ST_J_ROT  = 5'd20;
    localparam logic [4:0] ST_J_WR   = 5'd21;
    localparam logic [4:0] ST_J_END  = 5'd22;
    localparam logic [4:0] ST_DONE   = 5'd23;

    localparam logic [1:0] STG_LEAD  = 2'd0;
    localparam logic [1:0] STG_ROUND = 2'd1;
    localparam logic [1:0] STG_TRAIL = 2'd2;

    localparam logic [1:0] JOB_LOOP = 2'd0;
    localparam logic [1:0] JOB_ZERO = 2'd1;
    localparam logic [1:0] JOB_LAST = 2'd2;

    // configuration
    logic [7:0] r_rounds;
    logic       r_mode;

    // sequencer
    logic [4:0]    r_state;
    logic [1:0]    r_stage;
    logic [1:0]    r_step;
    logic [7:0]    r_rnd;
    logic [8:0]    r_rem;
    logic [7:0]    r_pa;
    logic [7:0]    r_pb;
    logic [7:0]    r_phase;
    logic          r_left;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_top;
    logic [LW-1:0] r_last;
    logic [LW-1:0] r_sc;
    logic [LW-1:0] r_pos;
    logic [7:0]    r_idx;
    logic [1:0]    r_job;
    logic [5:0]    r_amt;
    logic [3:0]    r_k;
    logic [63:0]   r_word;

    // result register
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_ostat;

    // memories
    logic [7:0] r_key_mem [0:KEY_BYTES-1];
    logic [7:0] r_buf_mem [0:BUF_DEPTH-1];
    logic [7:0] r_key_q;
    logic [7:0] r_buf_q;

    logic [11:0]       in_loc;
    logic [7:0]        in_dat;
    logic [12:0]       in_len;
    logic              s_accept;
    logic              loc_key_bad;
    logic              loc_buf_bad;
    logic              len_bad;

    logic [KEY_AW-1:0] key_addr;
    logic [KEY_AW-1:0] seq_key_addr;
    logic [KEY_AW-1:0] bld_key_addr;
    logic              key_we;
    logic [AW-1:0]     buf_raddr;
    logic              buf_we;
    logic [AW-1:0]     buf_waddr;
    logic [7:0]        buf_wdata;
    logic [TBL_AW-1:0] tbl_addr;
    logic              tbl_inv;
    logic [7:0]        tbl_q;
    t_tbl_wr           tbl_wr;
    logic              bld_start;
    logic              bld_done;

    logic [1:0]    cur_op;
    logic [7:0]    cur_phase;
    logic [1:0]    cur_job;
    logic [LW-1:0] pos_k;
    logic [31:0]   i_ext;
    logic [31:0]   sc_ext;
    logic          res_set;
    logic [7:0]    res_byte;
    logic          res_stat;

    function automatic logic [63:0] rot64(input logic [63:0] w, input logic [5:0] amt,
                                          input logic left);
        logic [5:0]   eff;
        logic [127:0] d;
        eff = left ? amt : 6'(6'd0 - amt);
        d   = {w, w} << eff;
        return d[127:64];
    endfunction

    assign in_loc   = i_s_axis_tdata[11:0];
    assign in_dat   = i_s_axis_tdata[19:12];
    assign in_len   = i_s_axis_tdata[32:20];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign loc_key_bad = in_loc >= 12'(KEY_BYTES);
    assign loc_buf_bad = {1'b0, in_loc} >= 13'(BUF_DEPTH);
    assign len_bad     = in_len > 13'(BUF_DEPTH);

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign bld_start       = s_accept && (i_s_axis_tuser == REQ_BUILD);

    assign pos_k  = r_pos + LW'(r_k);
    assign i_ext  = 32'(r_i);
    assign sc_ext = 32'(r_sc);

    // operation and phase of the pass about to start
    always_comb begin
        if (r_stage != STG_ROUND) begin
            cur_op = OP_XOR;
        end else if (!r_mode) begin
            case (r_step)
                2'd0:    cur_op = OP_SUB;
                2'd1:    cur_op = OP_ROTL;
                2'd2:    cur_op = OP_XOR;
                default: cur_op = OP_ROTR;
            endcase
        end else begin
            case (r_step)
                2'd0:    cur_op = OP_ROTL;
                2'd1:    cur_op = OP_XOR;
                2'd2:    cur_op = OP_ROTR;
                default: cur_op = OP_SUB;
            endcase
        end
        if (r_mode)
            cur_phase = (r_step == 2'd0) ? r_pb : r_pa;
        else
            cur_phase = (r_step == 2'd3) ? r_pb : r_pa;
    end

    // word jobs of a rotation pass; left order is loop, zero, last
    always_comb begin
        if (r_left)
            cur_job = r_job;
        else
            cur_job = JOB_LAST - r_job;
    end

    always_comb begin
        case (r_state)
            ST_PHA:  seq_key_addr = {2'b00, r_rnd};
            ST_PHB:  seq_key_addr = {2'b10, r_rnd};
            default: seq_key_addr = i_ext[KEY_AW-1:0];
        endcase
        key_addr = (r_state == ST_BUILD) ? bld_key_addr : seq_key_addr;
        key_we   = s_accept && (i_s_axis_tuser == REQ_KEY_WR) && !loc_key_bad;
    end

    always_comb begin
        case (r_state)
            ST_IDLE: buf_raddr = in_loc[AW-1:0];
            ST_J_LD: buf_raddr = pos_k[AW-1:0];
            default: buf_raddr = r_i[AW-1:0];
        endcase
        buf_we    = 1'b0;
        buf_waddr = r_i[AW-1:0];
        buf_wdata = tbl_q;
        case (r_state)
            ST_IDLE: begin
                buf_we    = s_accept && (i_s_axis_tuser == REQ_BUF_WR) && !loc_buf_bad;
                buf_waddr = in_loc[AW-1:0];
                buf_wdata = in_dat;
            end
            ST_X_WR: begin
                buf_we    = 1'b1;
                buf_wdata = r_buf_q ^ r_key_q ^ 8'hff;
            end
            ST_S_WR: buf_we = 1'b1;
            ST_J_WR: begin
                buf_we    = 1'b1;
                buf_waddr = pos_k[AW-1:0];
                buf_wdata = r_word[8*r_k[2:0] +: 8];
            end
            default: buf_we = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_S_TB:  tbl_addr = {r_phase, r_buf_q};
            ST_R_127: tbl_addr = {r_phase, 8'd127};
            default:  tbl_addr = {r_phase, r_idx};
        endcase
        tbl_inv = (r_state == ST_S_TB) && r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (key_we)
            r_key_mem[in_loc[KEY_AW-1:0]] <= in_dat;
        r_key_q <= r_key_mem[key_addr];
        if (buf_we)
            r_buf_mem[buf_waddr] <= buf_wdata;
        r_buf_q <= r_buf_mem[buf_raddr];
    end

    kbc_builder u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (bld_start),
        .o_key_addr (bld_key_addr),
        .i_key_data (r_key_q),
        .o_wr       (tbl_wr),
        .o_done     (bld_done)
    );

    kbc_tables u_tables (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (tbl_addr),
        .i_rd_inv  (tbl_inv),
        .o_rd_data (tbl_q)
    );

    // results
    always_comb begin
        res_set  = 1'b0;
        res_byte = 8'd0;
        res_stat = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        REQ_KEY_WR: begin
                            res_set  = 1'b1;
                            res_stat = loc_key_bad;
                        end
                        REQ_BUF_WR: begin
                            res_set  = 1'b1;
                            res_stat = loc_buf_bad;
                        end
                        REQ_BUF_RD: begin
                            res_set  = loc_buf_bad;
                            res_stat = 1'b1;
                        end
                        REQ_RUN: begin
                            res_set  = len_bad || (in_len == 13'd0);
                            res_stat = len_bad;
                        end
                        REQ_BUILD: res_set = 1'b0;
                        default: begin
                            res_set  = 1'b1;
                            res_stat = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDBUF: begin
                res_set  = 1'b1;
                res_byte = r_buf_q;
            end
            ST_BUILD: res_set = bld_done;
            ST_DONE:  res_set = 1'b1;
            default:  res_set = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_set) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (res_set) begin
            r_obyte <= res_byte;
            r_ostat <= res_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= 8'd4;
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROUNDS)
                r_rounds <= i_cfg_wdata;
            else
                r_mode <= i_cfg_wdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (i_s_axis_tuser)
                            REQ_BUILD: r_state <= ST_BUILD;
                            REQ_BUF_RD: if (!loc_buf_bad) r_state <= ST_RDBUF;
                            REQ_RUN: begin
                                if (!len_bad && in_len != 13'd0) begin
                                    r_len <= LW'(in_len);
                                    r_rem <= {1'b0, r_rounds};
                                    if (r_mode) begin
                                        r_rnd   <= r_rounds - 8'd1;
                                        r_stage <= STG_ROUND;
                                        r_state <= ST_RND;
                                    end else begin
                                        r_rnd   <= 8'd0;
                                        r_stage <= STG_LEAD;
                                        r_state <= ST_PASS;
                                    end
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_RDBUF: r_state <= ST_IDLE;
                ST_BUILD: if (bld_done) r_state <= ST_IDLE;
                ST_RND: begin
                    r_step <= 2'd0;
                    if (r_rem == 9'd0) begin
                        if (r_mode) begin
                            r_stage <= STG_TRAIL;
                            r_state <= ST_PASS;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_state <= ST_PHA;
                    end
                end
                ST_PHA: r_state <= ST_PHB;
                ST_PHB: begin
                    r_pa    <= r_key_q;
                    r_state <= ST_PHC;
                end
                ST_PHC: begin
                    r_pb    <= r_key_q;
                    r_state <= ST_PASS;
                end
                ST_PASS: begin
                    r_i     <= '0;
                    r_phase <= cur_phase;
                    r_left  <= (cur_op == OP_ROTL);
                    r_top   <= r_len - LW'(8);
                    r_last  <= (r_len == LW'(8)) ? '0 : r_len - LW'(9);
                    case (cur_op)
                        OP_XOR: r_state <= ST_X_RD;
                        OP_SUB: r_state <= ST_S_RD;
                        default: r_state <= (r_len < LW'(8)) ? ST_NEXT : ST_R_127;
                    endcase
                end
                ST_NEXT: begin
                    if (r_stage == STG_LEAD) begin
                        r_stage <= STG_ROUND;
                        r_state <= ST_RND;
                    end else if (r_stage == STG_ROUND) begin
                        if (r_step == 2'd3) begin
                            r_rem   <= r_rem - 9'd1;
                            r_rnd   <= r_mode ? r_rnd - 8'd1 : r_rnd + 8'd1;
                            r_state <= ST_RND;
                        end else begin
                            r_step  <= r_step + 2'd1;
                            r_state <= ST_PASS;
                        end
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_X_RD: r_state <= ST_X_WR;
                ST_X_WR: begin
                    r_i     <= r_i + LW'(1);
                    r_state <= (r_i + LW'(1) == r_len) ? ST_NEXT : ST_X_RD;
                end
                ST_S_RD: r_state <= ST_S_TB;
                ST_S_TB: r_state <= ST_S_WR;
                ST_S_WR: begin
                    r_i     <= r_i + LW'(1);
                    r_state <= (r_i + LW'(1) == r_len) ? ST_NEXT : ST_S_RD;
                end
                ST_R_127: r_state <= ST_R_127C;
                ST_R_127C: begin
                    r_sc    <= LW'(tbl_q[2:0]);
                    r_job   <= '0;
                    r_state <= ST_J_SEL;
                end
                ST_J_SEL: begin
                    if (r_job == 2'd3) begin
                        r_state <= ST_NEXT;
                    end else begin
                        case (cur_job)
                            JOB_LOOP: begin
                                if (r_sc < r_top) begin
                                    r_pos   <= r_sc;
                                    r_idx   <= sc_ext[11:4];
                                    r_state <= ST_J_AMT;
                                end else begin
                                    r_job <= r_job + 2'd1;
                                end
                            end
                            JOB_ZERO: begin
                                r_pos   <= '0;
                                r_idx   <= 8'd0;
                                r_state <= ST_J_AMT;
                            end
                            default: begin
                                r_pos   <= r_last;
                                r_idx   <= 8'd1;
                                r_state <= ST_J_AMT;
                            end
                        endcase
                    end
                end
                ST_J_AMT: r_state <= ST_J_AMTC;
                ST_J_AMTC: begin
                    r_amt   <= tbl_q[5:0];
                    r_k     <= '0;
                    // a zero rotation leaves the word alone
                    r_state <= (tbl_q[5:0] == 6'd0) ? ST_J_END : ST_J_LD;
                end
                ST_J_LD: begin
                    if (r_k != 4'd0)
                        r_word[{3'(r_k[2:0] - 3'd1), 3'b000} +: 8] <= r_buf_q;
                    r_k     <= r_k + 4'd1;
                    if (r_k == 4'd8)
                        r_state <= ST_J_ROT;
                end
                ST_J_ROT: begin
                    r_word  <= rot64(r_word, r_amt, r_left);
                    r_k     <= '0;
                    r_state <= ST_J_WR;
                end
                ST_J_WR: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd7)
                        r_state <= ST_J_END;
                end
                ST_J_END: begin
                    if (cur_job == JOB_LOOP)
                        r_sc <= r_sc + LW'(8);
                    else
                        r_job <= r_job + 2'd1;
                    r_state <= ST_J_SEL;
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tuser  = r_ostat;

    a_bld_done_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bld_done |-> r_state == ST_BUILD)
        else $error("table build finished outside build state");

    a_byte_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_X_WR || r_state == ST_S_WR) |-> r_i < r_len)
        else $error("byte pass wrote beyond run length");

    a_word_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_J_WR |-> pos_k < r_len)
        else $error("word rotation wrote beyond run length");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_set |-> (!r_ovalid || i_m_axis_tready))
        else $error("result overwrote a pending transaction");

endmodule

@@ rtl/kbc_tables.sv @@
// Forward and inverse permutation tables, 256 rows of 256 bytes each.
// Depends on kbc_pkg; written by kbc_builder, read by the run sequencer.
module kbc_tables import kbc_pkg::*; (
    input  logic              i_clk,
    input  t_tbl_wr           i_wr,
    input  logic [TBL_AW-1:0] i_rd_addr,
    input  logic              i_rd_inv,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_fwd_mem [0:(1<<TBL_AW)-1];
    logic [7:0] r_inv_mem [0:(1<<TBL_AW)-1];
    logic [7:0] r_fwd_q;
    logic [7:0] r_inv_q;
    logic       r_sel_inv;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_fwd_mem[i_wr.fwd_addr] <= i_wr.fwd_data;
            r_inv_mem[i_wr.inv_addr] <= i_wr.inv_data;
        end
        r_fwd_q   <= r_fwd_mem[i_rd_addr];
        r_inv_q   <= r_inv_mem[i_rd_addr];
        r_sel_inv <= i_rd_inv;
    end

    assign o_rd_data = r_sel_inv ? r_inv_q : r_fwd_q;

endmodule

@@ rtl/kbc_builder.sv @@
// Table build engine: walks the key store and fills both permutation tables.
// Depends on kbc_pkg; one key read per entry, one free-slot probe per cycle.
module kbc_builder import kbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic [KEY_AW-1:0] o_key_addr,
    input  logic [7:0]        i_key_data,
    output t_tbl_wr           o_wr,
    output logic              o_done
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_K1    = 3'd1;
    localparam logic [2:0] B_K2    = 3'd2;
    localparam logic [2:0] B_K3    = 3'd3;
    localparam logic [2:0] B_RD    = 3'd4;
    localparam logic [2:0] B_CALC  = 3'd5;
    localparam logic [2:0] B_PROBE = 3'd6;

    logic [2:0]        r_state;
    logic [7:0]        r_c;
    logic [7:0]        r_f;
    logic [7:0]        r_n;
    logic [7:0]        r_m;
    logic [KEY_AW-1:0] r_kp;
    logic [255:0]      r_used;
    logic              r_done;
    logic [7:0]        x_val;

    always_comb begin
        case (r_state)
            B_K1:    o_key_addr = KEY_AW'(KEY_BYTES - 1);
            B_K2:    o_key_addr = '0;
            default: o_key_addr = r_kp;
        endcase
    end

    always_comb begin
        if (r_n[0])
            x_val = r_c + i_key_data + 8'd1;
        else
            x_val = r_c - i_key_data + 8'd129;
    end

    always_comb begin
        o_wr.we       = (r_state == B_PROBE) && !r_used[r_f];
        o_wr.fwd_addr = {r_n, r_m};
        o_wr.fwd_data = r_f;
        o_wr.inv_addr = {r_n, r_f};
        o_wr.inv_data = r_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: if (i_start) r_state <= B_K1;
                B_K1:   r_state <= B_K2;
                B_K2: begin
                    r_c     <= i_key_data;
                    r_state <= B_K3;
                end
                B_K3: begin
                    r_c     <= r_c + i_key_data + 8'd129;
                    r_n     <= '0;
                    r_m     <= '0;
                    r_kp    <= '0;
                    r_used  <= '0;
                    r_state <= B_RD;
                end
                B_RD: r_state <= B_CALC;
                B_CALC: begin
                    r_c     <= r_n ^ x_val;
                    r_f     <= r_n ^ x_val;
                    r_state <= B_PROBE;
                end
                B_PROBE: begin
                    if (r_used[r_f]) begin
                        r_f <= r_f + 8'd1;
                    end else begin
                        r_used[r_f] <= 1'b1;
                        r_kp        <= r_kp + KEY_AW'(1);
                        r_m         <= r_m + 8'd1;
                        r_state     <= B_RD;
                        if (r_m == 8'hff) begin
                            r_used <= '0;
                            r_n    <= r_n + 8'd1;
                            if (r_n == 8'hff) begin
                                r_done  <= 1'b1;
                                r_state <= B_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done = r_done;

endmodule
